// ----- rtl/core/pms_pkg.sv -----
// Shared types, constants and helpers for the pattern mask stream core.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package pms_pkg;

	localparam int MAX_PATTERN = 8;
	localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int CHAR_W      = 8;
	localparam int PAT_BYTES   = 8;
	localparam int LEN_REG_W   = 4;
	localparam int PAT_REG_W   = PAT_BYTES * CHAR_W;

	localparam int APB_ADDR_W   = 4;
	localparam int APB_DATA_W   = 64;
	localparam int CFG_ADDR_LSB = 3;

	localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;

	typedef logic [CHAR_W-1:0] char_t;

	typedef enum logic {
		CFG_PATTERN_LEN   = 1'b0,
		CFG_PATTERN_BYTES = 1'b1
	} cfg_reg_t;

	// One burst of output items produced by a single input item
	typedef struct packed {
		char_t [MAX_PATTERN-1:0] chars;
		logic [CNT_W-1:0]        len;
		logic                    last;
	} burst_t;

	// Clamp the programmed length into 1..MAX_PATTERN
	function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_REG_W-1:0] n);
		logic [CNT_W-1:0] r;
		if (n == '0) begin
			r = CNT_W'(1);
		end else if (int'(n) > MAX_PATTERN) begin
			r = CNT_W'(MAX_PATTERN);
		end else begin
			r = CNT_W'(n);
		end
		return r;
	endfunction

	// Pattern byte k; positions past the register compare as zero
	function automatic char_t pat_byte(input logic [PAT_REG_W-1:0] bytes, input int k);
		char_t r;
		if (k >= PAT_BYTES) begin
			r = '0;
		end else begin
			r = bytes[CHAR_W*k +: CHAR_W];
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/pms_cfg_regs.sv -----
// APB register file: pattern length and packed pattern bytes.
// Depends on pms_pkg.
`timescale 1ns / 1ps

module pms_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pms_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [pms_pkg::APB_DATA_W-1:0] pwdata,
	output logic [pms_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output logic [pms_pkg::LEN_REG_W-1:0]  pattern_len,
	output logic [pms_pkg::PAT_REG_W-1:0]  pattern_bytes
);
	import pms_pkg::*;

	logic [LEN_REG_W-1:0] pattern_len_q;
	logic [PAT_REG_W-1:0] pattern_bytes_q;
	cfg_reg_t             reg_sel;
	logic                 wr_en;

	assign pready  = 1'b1;
	assign reg_sel = cfg_reg_t'(paddr[CFG_ADDR_LSB]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_len_q   <= LEN_REG_W'(1);
			pattern_bytes_q <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				CFG_PATTERN_LEN:   pattern_len_q   <= pwdata[LEN_REG_W-1:0];
				CFG_PATTERN_BYTES: pattern_bytes_q <= pwdata[PAT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			CFG_PATTERN_LEN:   prdata = APB_DATA_W'(pattern_len_q);
			CFG_PATTERN_BYTES: prdata = APB_DATA_W'(pattern_bytes_q);
			default:           prdata = '0;
		endcase
	end

	assign pattern_len   = pattern_len_q;
	assign pattern_bytes = pattern_bytes_q;

endmodule

// ----- rtl/core/pms_match.sv -----
// Input register, pending window and combinational window compare.
// Turns each item into a burst of up to MAX_PATTERN output bytes. Depends on pms_pkg.
`timescale 1ns / 1ps

module pms_match (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  pms_pkg::char_t                in_char,
	input  logic                          in_last,
	input  logic [pms_pkg::LEN_REG_W-1:0] pattern_len,
	input  logic [pms_pkg::PAT_REG_W-1:0] pattern_bytes,
	output logic                          burst_vld,
	input  logic                          burst_ready,
	output pms_pkg::burst_t               burst
);
	import pms_pkg::*;

	logic             item_vld_s1;
	char_t            char_s1;
	logic             last_s1;

	char_t            window_q [MAX_PATTERN];
	logic [CNT_W-1:0] count_q;

	char_t            seq      [MAX_PATTERN];
	char_t            window_d [MAX_PATTERN];
	logic [CNT_W:0]   pk       [MAX_PATTERN];
	logic [CNT_W:0]   src      [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] match_vec;
	logic [CNT_W-1:0] len, m, p, e, cnt_d;
	logic             full, hit, fire;

	always_comb begin
		len = eff_len(pattern_len);
		m   = count_q + 1'b1;
		full = (m >= len);
		p   = m - len;

		// Pending bytes followed by the new one
		for (int j = 0; j < MAX_PATTERN; j++) begin
			seq[j] = (CNT_W'(j) == count_q) ? char_s1 : window_q[j];
		end

		// Compare the youngest len bytes against the pattern
		for (int k = 0; k < MAX_PATTERN; k++) begin
			pk[k] = {1'b0, p} + (CNT_W + 1)'(k);
			match_vec[k] = (CNT_W'(k) >= len) ||
				((pk[k] < (CNT_W + 1)'(MAX_PATTERN)) &&
				(seq[pk[k][IDX_W-1:0]] == pat_byte(pattern_bytes, k)));
		end
		hit = full && (&match_vec);

		// Emit a prefix: all on a hit or a flush, up to the oldest byte on a miss, none while filling
		if (full && !hit && !last_s1) begin
			e = p + 1'b1;
		end else if (full || last_s1) begin
			e = m;
		end else begin
			e = '0;
		end
		cnt_d = m - e;

		for (int j = 0; j < MAX_PATTERN; j++) begin
			burst.chars[j] = (hit && (CNT_W'(j) >= p)) ? STAR_CHAR : seq[j];
			src[j] = {1'b0, e} + (CNT_W + 1)'(j);
			window_d[j] = (src[j] < (CNT_W + 1)'(MAX_PATTERN)) ?
				seq[src[j][IDX_W-1:0]] : seq[j];
		end
		burst.len  = e;
		burst.last = last_s1;
	end

	assign fire      = item_vld_s1 && burst_ready;
	assign burst_vld = fire && (e != '0);
	assign in_ready  = !item_vld_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
			count_q     <= '0;
		end else begin
			if (in_ready) begin
				item_vld_s1 <= in_valid;
			end
			if (fire) begin
				count_q <= cnt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= in_char;
			last_s1 <= in_last;
		end
		if (fire) begin
			window_q <= window_d;
		end
	end

	// A flush or a hit leaves the window empty
	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_s1 |=> count_q == '0)
		else $error("window not empty after flush");

	a_hit_empties: assert property (@(posedge clk) disable iff (!arst_n)
		fire && hit |=> count_q == '0)
		else $error("window not empty after match");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(count_q))
		else $error("window count moved without an item");

endmodule

// ----- rtl/core/pms_burst_out.sv -----
// Burst register and output serializer: one byte per cycle while m_ready holds.
// Depends on pms_pkg.
`timescale 1ns / 1ps

module pms_burst_out (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            burst_vld,
	output logic            burst_ready,
	input  pms_pkg::burst_t burst,
	output logic            m_valid,
	input  logic            m_ready,
	output pms_pkg::char_t  m_char,
	output logic            m_last
);
	import pms_pkg::*;

	burst_t           burst_q;
	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	logic             at_end;
	logic             take;

	assign at_end      = (CNT_W'(idx_q) == burst_q.len - 1'b1);
	assign take        = busy_q && m_ready;
	assign burst_ready = !busy_q || (m_ready && at_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (burst_vld) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (take) begin
			if (at_end) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (burst_vld) begin
			burst_q <= burst;
		end
	end

	assign m_valid = busy_q;
	assign m_char  = burst_q.chars[idx_q];
	assign m_last  = burst_q.last && at_end;

	a_idx_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> CNT_W'(idx_q) < burst_q.len)
		else $error("serializer index past burst length");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !m_ready |=> busy_q && $stable(idx_q))
		else $error("serializer advanced while stalled");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		burst_vld |-> burst_ready)
		else $error("burst loaded over a pending one");

endmodule

// ----- rtl/core/pattern_mask_stream_core.sv -----
// Top level of the pattern mask stream core: replaces pattern hits with '*'.
// Depends on pms_pkg, pms_cfg_regs, pms_match and pms_burst_out.
//
//  channel   | direction | payload                        | handshake
//  ----------+-----------+--------------------------------+------------------------
//  s_axis    | in        | tdata[7:0]=in_char, tlast      | tvalid/tready
//  m_axis    | out       | tdata[7:0]=out_char, tlast     | tvalid/tready
//  apb       | in        | 0x0 pattern_len, 0x8 pattern   | psel/penable, pready=1
//
// An item waits in the input register, then its burst of output bytes is
// loaded into the burst register and sent one byte per cycle while the
// receiver is ready. Items yielding at most one byte sustain one item per
// cycle while it is ready; after an item that emits several bytes (a match,
// a flush on tlast, or the excess left pending by a shorter length, up to 8),
// the next item waits until the single-byte output port has sent them all.
// Reset clears the window count and the valid flags; no clearing pass is needed.
`timescale 1ns / 1ps

module pattern_mask_stream_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // [7:0] in_char
	input  logic                           s_axis_tlast,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [7:0]                     m_axis_tdata,  // [7:0] out_char
	output logic                           m_axis_tlast,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pms_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [pms_pkg::APB_DATA_W-1:0] pwdata,
	output logic [pms_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import pms_pkg::*;

	logic [LEN_REG_W-1:0] pattern_len;
	logic [PAT_REG_W-1:0] pattern_bytes;
	logic                 burst_vld;
	logic                 burst_ready;
	burst_t               burst;

	pms_cfg_regs u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.pattern_len   (pattern_len),
		.pattern_bytes (pattern_bytes)
	);

	pms_match u_match (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_char       (s_axis_tdata),
		.in_last       (s_axis_tlast),
		.pattern_len   (pattern_len),
		.pattern_bytes (pattern_bytes),
		.burst_vld     (burst_vld),
		.burst_ready   (burst_ready),
		.burst         (burst)
	);

	pms_burst_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.burst_vld   (burst_vld),
		.burst_ready (burst_ready),
		.burst       (burst),
		.m_valid     (m_axis_tvalid),
		.m_ready     (m_axis_tready),
		.m_char      (m_axis_tdata),
		.m_last      (m_axis_tlast)
	);

endmodule

// ----- bench/pms_checker.sv -----
// Checker for pattern_mask_stream_core: follows APB writes, predicts the masked
// byte stream for every accepted text item and compares each output item.
// Depends on pms_pkg for widths, register codes and the asterisk constant.
`timescale 1ns / 1ps

module pms_checker
	import pms_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,  // [7:0] in_char
	input  logic                  s_axis_tlast,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [7:0]            m_axis_tdata,  // [7:0] out_char
	input  logic                  m_axis_tlast,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic                  pready,
	output int unsigned           fail_count,
	output int unsigned           outstanding,
	output int unsigned           text_bytes,
	output int unsigned           out_bytes,
	output int unsigned           masked_runs,
	output int unsigned           cfg_writes
);

	typedef struct packed {
		logic  last;
		char_t chr;
	} masked_item_t;

	logic [LEN_REG_W-1:0] pat_len_q;
	logic [PAT_REG_W-1:0] pat_bytes_q;
	char_t                window [MAX_PATTERN];
	int unsigned          window_cnt;
	masked_item_t         masked_due [$];
	masked_item_t         head;
	int unsigned          shown;

	task automatic report_mismatch(input string what);
		fail_count++;
		if (shown < 40) begin
			shown++;
			$display("%0t ns: [check] %s", $time, what);
		end
	endtask

	// Drop the oldest pending byte into the output, unchanged
	task automatic release_oldest();
		masked_item_t it;
		it.chr  = window[0];
		it.last = 1'b0;
		for (int k = 1; k < MAX_PATTERN; k++)
			window[k-1] = window[k];
		if (window_cnt > 0)
			window_cnt--;
		masked_due.push_back(it);
	endtask

	task automatic mask_step(input char_t c, input logic is_last);
		int unsigned  len;
		int unsigned  base;
		logic         hit;
		masked_item_t it;
		base = masked_due.size();
		if (pat_len_q == '0)
			len = 1;
		else if (pat_len_q > MAX_PATTERN)
			len = MAX_PATTERN;
		else
			len = pat_len_q;

		// A shorter length may leave too many bytes pending: flush the excess first
		while (window_cnt >= len && window_cnt > 0)
			release_oldest();
		if (window_cnt < MAX_PATTERN) begin
			window[window_cnt] = c;
			window_cnt++;
		end

		if (window_cnt == len) begin
			hit = 1'b1;
			for (int k = 0; k < len; k++)
				if (window[k] != pat_bytes_q[CHAR_W*k +: CHAR_W])
					hit = 1'b0;
			if (hit) begin
				it.chr  = STAR_CHAR;
				it.last = 1'b0;
				for (int k = 0; k < len; k++)
					masked_due.push_back(it);
				window_cnt = 0;
				masked_runs++;
			end else begin
				release_oldest();
			end
		end

		if (is_last) begin
			while (window_cnt > 0)
				release_oldest();
			if (masked_due.size() > base) begin
				it = masked_due.pop_back();
				it.last = 1'b1;
				masked_due.push_back(it);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len_q   = LEN_REG_W'(1);
			pat_bytes_q = '0;
			window_cnt  = 0;
			masked_due.delete();
			fail_count  = 0;
			text_bytes  = 0;
			out_bytes   = 0;
			masked_runs = 0;
			cfg_writes  = 0;
			shown       = 0;
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				cfg_writes++;
				case (cfg_reg_t'(paddr[APB_ADDR_W-1:CFG_ADDR_LSB]))
					CFG_PATTERN_LEN:   pat_len_q = pwdata[LEN_REG_W-1:0];
					CFG_PATTERN_BYTES: pat_bytes_q = pwdata[PAT_REG_W-1:0];
					default: ;
				endcase
			end

			// Compare outputs before queuing this edge's input, so a stray byte
			// can never consume an expectation that was just created
			if (m_axis_tvalid && m_axis_tready) begin
				out_bytes++;
				if (masked_due.size() == 0) begin
					report_mismatch($sformatf("output 0x%02h (last %0b) with nothing expected",
						m_axis_tdata, m_axis_tlast));
				end else begin
					head = masked_due.pop_front();
					if (m_axis_tdata !== head.chr)
						report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
							m_axis_tdata, head.chr));
					if (m_axis_tlast !== head.last)
						report_mismatch($sformatf("out_last %0b, expected %0b on byte 0x%02h",
							m_axis_tlast, head.last, head.chr));
				end
			end

			if (s_axis_tvalid && s_axis_tready) begin
				text_bytes++;
				mask_step(s_axis_tdata, s_axis_tlast);
			end

			outstanding <= masked_due.size();
		end
	end

endmodule

// ----- bench/tb.sv -----
// Testbench top for pattern_mask_stream_core: sends text and pattern settings
// with random stalls on both streams and reports the verdict.
// Depends on pms_pkg, pms_checker and the core itself.
`timescale 1ns / 1ps

module tb;
	import pms_pkg::*;

	localparam int DRAIN_CYCLES = 12;
	localparam int QUIET_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 80;
	localparam int RANDOM_ITEMS = 180;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata;  // [7:0] in_char
	logic                  s_axis_tlast;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [7:0]            m_axis_tdata;  // [7:0] out_char
	logic                  m_axis_tlast;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned text_bytes;
	int unsigned out_bytes;
	int unsigned masked_runs;
	int unsigned cfg_writes;

	logic                 steady;
	logic                 hold_req;
	logic [LEN_REG_W-1:0] cur_len;
	logic [PAT_REG_W-1:0] cur_pat;
	int unsigned          random_sent;

	pattern_mask_stream_core u_top (.*);
	pms_checker              u_check (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_char(input char_t c, input logic is_last);
		while (!steady && $urandom_range(99) < 34) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= is_last;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_word(input logic [63:0] bytes, input int unsigned n,
			input logic end_text);
		for (int k = 0; k < n; k++)
			send_char(bytes[8*k +: 8], end_text && (k == n - 1));
	endtask

	// Hold the sender until every predicted byte is out, then let the core empty
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input cfg_reg_t which, input logic [APB_DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= APB_ADDR_W'(which) << CFG_ADDR_LSB;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (which == CFG_PATTERN_LEN)
			cur_len = value[LEN_REG_W-1:0];
		else
			cur_pat = value[PAT_REG_W-1:0];
	endtask

	// Small alphabet so that partial and repeated matches come up often
	function automatic char_t alpha_byte();
		case ($urandom_range(3))
			0: return 8'h61;
			1: return 8'h62;
			2: return 8'h00;
			default: return STAR_CHAR;
		endcase
	endfunction

	task automatic pick_setting();
		logic [APB_DATA_W-1:0] len_word;
		logic [APB_DATA_W-1:0] pat_word;
		int unsigned           r;
		r = $urandom_range(99);
		len_word = {$urandom, $urandom};
		if (r < 12)
			len_word[LEN_REG_W-1:0] = '0;
		else if (r < 24)
			len_word[LEN_REG_W-1:0] = LEN_REG_W'($urandom_range(15, MAX_PATTERN + 1));
		else
			len_word[LEN_REG_W-1:0] = LEN_REG_W'($urandom_range(MAX_PATTERN, 1));
		pat_word = {$urandom, $urandom};
		if ($urandom_range(3) != 0)
			for (int k = 0; k < PAT_BYTES; k++)
				pat_word[CHAR_W*k +: CHAR_W] = alpha_byte();
		if ($urandom_range(1)) begin
			reg_write(CFG_PATTERN_BYTES, pat_word);
			reg_write(CFG_PATTERN_LEN, len_word);
		end else begin
			reg_write(CFG_PATTERN_LEN, len_word);
			reg_write(CFG_PATTERN_BYTES, pat_word);
		end
	endtask

	// Build a text mostly from pattern copies and broken prefixes, then send it;
	// optionally change the setting part way through
	task automatic send_text(input int unsigned n, input logic relen);
		char_t       text [$];
		int unsigned plen;
		int unsigned pick;
		int unsigned cut;
		int unsigned part;
		plen = (cur_len == '0) ? 1 : ((cur_len > MAX_PATTERN) ? MAX_PATTERN : cur_len);
		while (text.size() < n) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				for (int k = 0; k < plen; k++)
					text.push_back(cur_pat[CHAR_W*k +: CHAR_W]);
			end else if (pick < 50) begin
				part = $urandom_range(plen - 1);
				for (int k = 0; k < part; k++)
					text.push_back(cur_pat[CHAR_W*k +: CHAR_W]);
				text.push_back(alpha_byte());
			end else if (pick < 75) begin
				text.push_back(alpha_byte());
			end else begin
				text.push_back(char_t'($urandom));
			end
		end
		cut = (relen && text.size() > 1) ? $urandom_range(text.size() - 1, 1) : text.size();
		for (int k = 0; k < text.size(); k++) begin
			if (k == cut) begin
				settle();
				pick_setting();
			end
			send_char(text[k], k == text.size() - 1);
			random_sent++;
		end
	endtask

	initial begin : rx_side
		int unsigned hold_left;
		hold_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= steady || ($urandom_range(99) >= 34);
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("pattern_mask_stream_core: mismatch");
		$finish;
	end

	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		steady        = 1'b0;
		hold_req      = 1'b0;
		cur_len       = LEN_REG_W'(1);
		cur_pat       = '0;
		random_sent   = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Zero length acts as one; a lone 0x00 pattern, '*' passes as plain text
		reg_write(CFG_PATTERN_LEN, '0);
		reg_write(CFG_PATTERN_BYTES, '0);
		send_char(8'h00, 1'b0);
		send_char(STAR_CHAR, 1'b0);
		send_char(8'hFF, 1'b1);
		settle();

		// Overlapping candidates: "ababax" against "aba" masks only the first
		reg_write(CFG_PATTERN_LEN, 64'd3);
		reg_write(CFG_PATTERN_BYTES, 64'h0000_0000_0061_6261);
		send_word(64'h0000_7861_6261_6261, 6, 1'b1);
		settle();

		// Length above range acts as eight; full-width hit on the final byte
		reg_write(CFG_PATTERN_LEN, 64'd15);
		reg_write(CFG_PATTERN_BYTES, '1);
		send_word('1, 8, 1'b1);
		settle();

		// Seven bytes pending, then shrink the length to one mid-text
		reg_write(CFG_PATTERN_LEN, 64'd8);
		reg_write(CFG_PATTERN_BYTES, 64'h4847_4645_4443_4241);
		send_word(64'h4847_4645_4443_4241, 7, 1'b0);
		settle();
		reg_write(CFG_PATTERN_LEN, 64'd1);
		send_char(8'h41, 1'b0);
		send_char(8'h7A, 1'b1);
		settle();

		// Receiver holds off while the sender keeps pushing a match-heavy text
		reg_write(CFG_PATTERN_LEN, 64'd3);
		reg_write(CFG_PATTERN_BYTES, 64'h0000_0000_002A_6261);
		steady   = 1'b1;
		hold_req = 1'b1;
		send_text(40, 1'b0);
		steady = 1'b0;
		settle();

		random_sent = 0;
		pick_setting();
		while (random_sent < RANDOM_ITEMS) begin
			if ($urandom_range(99) < 30) begin
				settle();
				pick_setting();
			end
			steady = (random_sent >= 100 && random_sent < 150);
			send_text($urandom_range(20, 1), $urandom_range(99) < 15);
		end
		steady = 1'b0;
		settle();

		$display("Run: %0d text bytes in, %0d bytes out, %0d masked runs, %0d register writes",
			text_bytes, out_bytes, masked_runs, cfg_writes);
		$display("Run: random stalls both sides, a held-off receiver, mid-text length changes");
		if (fail_count == 0 && outstanding == 0)
			$display("pattern_mask_stream_core: match");
		else
			$display("pattern_mask_stream_core: mismatch");
		$finish;
	end

endmodule
